// ===== rtl/core/sbox_pkg.sv =====
// sbox_pkg: shared types, constants and gf(2^8) helper functions for the aes s-box pipeline
// no dependencies; imported by aes_sbox_byte_substitution

package sbox_pkg;

    localparam logic [7:0] ReduceLow  = 8'h1b;  // low byte of the field polynomial 0x11b
    localparam logic [7:0] AffineC    = 8'h63;  // forward affine constant
    localparam logic [7:0] InvAffineC = 8'h05;  // inverse affine constant

    // payload of each pipeline stage
    typedef struct packed {
        logic       dir;
        logic [7:0] x;
        logic [7:0] x2;
    } s0_t;

    typedef struct packed {
        logic       dir;
        logic [7:0] x2;
        logic [7:0] x3;
    } s1_t;

    typedef struct packed {
        logic       dir;
        logic [7:0] x2;
        logic [7:0] x12;
        logic [7:0] x15;
    } s2_t;

    typedef struct packed {
        logic       dir;
        logic [7:0] x2;
        logic [7:0] x252;
    } s3_t;

    typedef struct packed {
        logic [7:0] out_byte;
    } s4_t;

    function automatic logic [7:0] rotl8(input logic [7:0] v, input int unsigned k);
        return (v << k) | (v >> (8 - k));
    endfunction

    // shift-and-add multiply with reduction by 0x11b
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] aa;
        acc = '0;
        aa  = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                acc = acc ^ aa;
            end
            aa = {aa[6:0], 1'b0} ^ (aa[7] ? ReduceLow : 8'h00);
        end
        return acc;
    endfunction

    function automatic logic [7:0] gf_sq(input logic [7:0] a);
        return gf_mul(a, a);
    endfunction

    function automatic logic [7:0] affine_fwd(input logic [7:0] b);
        return b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ AffineC;
    endfunction

    function automatic logic [7:0] affine_inv(input logic [7:0] s);
        return rotl8(s, 1) ^ rotl8(s, 3) ^ rotl8(s, 6) ^ InvAffineC;
    endfunction

endpackage

// ===== rtl/core/sbox_if.sv =====
// sbox_in_if / sbox_out_if: valid-ready byte channels of the s-box core
// no dependencies

interface sbox_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface sbox_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink (input valid, input out_byte, output ready);
endinterface

// ===== rtl/core/aes_sbox_byte_substitution.sv =====
// aes_sbox_byte_substitution: pipelined forward / inverse aes s-box
// depends on sbox_pkg, sbox_if (channel interfaces) and sbox_stage

// The block substitutes one byte per beat with the AES S-box, or with the
// inverse S-box when the direction register is set (cfg_we writes cfg_wdata
// into it; write it only while no beat is in flight). The field inverse is
// computed as x^254 with the addition chain x^2, x^3, x^12, x^15, x^240,
// x^252, x^254: at most one GF(2^8) multiply per register stage, with the
// squarings folded in beside it. A new byte is accepted in every cycle while
// the output side is ready or some stage is empty; each result passes the
// stage 0 to 4 registers in order and leaves when the output side is ready.
// Every stage holds a valid bit and accepts a new beat whenever it is empty
// or its beat moves on, so back-pressure on the output fills bubbles first
// and never drops or repeats a beat. Up to five beats are in flight.

module aes_sbox_byte_substitution
    import sbox_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    sbox_in_if.sink           in_ch,
    sbox_out_if.source        out_ch
);

    logic dir_reg;

    // direction register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            dir_reg <= cfg_wdata;
        end
    end

    // stage payloads: *_d enters a stage, *_q leaves it
    s0_t s0_d, s0_q;
    s1_t s1_d, s1_q;
    s2_t s2_d, s2_q;
    s3_t s3_d, s3_q;
    s4_t s4_d, s4_q;

    logic s0_valid, s1_valid, s2_valid, s3_valid, s4_valid;
    logic s1_ready, s2_ready, s3_ready, s4_ready;

    logic [7:0] x_in;
    logic [7:0] x240;
    logic [7:0] x254;

    // stage 0: inverse affine first when running the inverse s-box, then square
    always_comb
    begin
        x_in       = dir_reg ? affine_inv(in_ch.in_byte) : in_ch.in_byte;
        s0_d.dir   = dir_reg;
        s0_d.x     = x_in;
        s0_d.x2    = gf_sq(x_in);
    end

    sbox_stage #(.W($bits(s0_t))) u_s0 (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_ch.valid),
        .up_ready (in_ch.ready),
        .up_data  (s0_d),
        .dn_valid (s0_valid),
        .dn_ready (s1_ready),
        .dn_data  (s0_q)
    );

    // stage 1: x^3
    always_comb
    begin
        s1_d.dir = s0_q.dir;
        s1_d.x2  = s0_q.x2;
        s1_d.x3  = gf_mul(s0_q.x2, s0_q.x);
    end

    sbox_stage #(.W($bits(s1_t))) u_s1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s0_valid),
        .up_ready (s1_ready),
        .up_data  (s1_d),
        .dn_valid (s1_valid),
        .dn_ready (s2_ready),
        .dn_data  (s1_q)
    );

    // stage 2: x^12 by two squarings, then x^15
    always_comb
    begin
        s2_d.dir = s1_q.dir;
        s2_d.x2  = s1_q.x2;
        s2_d.x12 = gf_sq(gf_sq(s1_q.x3));
        s2_d.x15 = gf_mul(s2_d.x12, s1_q.x3);
    end

    sbox_stage #(.W($bits(s2_t))) u_s2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s1_valid),
        .up_ready (s2_ready),
        .up_data  (s2_d),
        .dn_valid (s2_valid),
        .dn_ready (s3_ready),
        .dn_data  (s2_q)
    );

    // stage 3: x^240 by four squarings (linear), then x^252
    always_comb
    begin
        x240      = gf_sq(gf_sq(gf_sq(gf_sq(s2_q.x15))));
        s3_d.dir  = s2_q.dir;
        s3_d.x2   = s2_q.x2;
        s3_d.x252 = gf_mul(x240, s2_q.x12);
    end

    sbox_stage #(.W($bits(s3_t))) u_s3 (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s2_valid),
        .up_ready (s3_ready),
        .up_data  (s3_d),
        .dn_valid (s3_valid),
        .dn_ready (s4_ready),
        .dn_data  (s3_q)
    );

    // stage 4: x^254 is the field inverse (zero stays zero), forward affine last in forward mode
    always_comb
    begin
        x254          = gf_mul(s3_q.x252, s3_q.x2);
        s4_d.out_byte = s3_q.dir ? x254 : affine_fwd(x254);
    end

    sbox_stage #(.W($bits(s4_t))) u_s4 (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s3_valid),
        .up_ready (s4_ready),
        .up_data  (s4_d),
        .dn_valid (s4_valid),
        .dn_ready (out_ch.ready),
        .dn_data  (s4_q)
    );

    assign out_ch.valid    = s4_valid;
    assign out_ch.out_byte = s4_q.out_byte;

    // a ready output side lets every stage move, so the input is never held off
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.ready |-> in_ch.ready)
        else $error("input stalled while output side is ready");

    // powers of a nonzero field element are nonzero, of zero are zero
    a_x3_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid |-> ((s1_q.x3 == 8'h00) == (s1_q.x2 == 8'h00)))
        else $error("x^3 zero pattern disagrees with x^2");

    a_x252_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid |-> ((s3_q.x252 == 8'h00) == (s3_q.x2 == 8'h00)))
        else $error("x^252 zero pattern disagrees with x^2");

endmodule

// ===== rtl/core/sbox_stage.sv =====
// sbox_stage: one valid-ready pipeline register of the s-box core
// no dependencies; instantiated by aes_sbox_byte_substitution

module sbox_stage #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         up_valid,
    output logic         up_ready,
    input  logic [W-1:0] up_data,
    output logic         dn_valid,
    input  logic         dn_ready,
    output logic [W-1:0] dn_data
);

    logic         valid_reg;
    logic [W-1:0] data_reg;

    // take a new beat when empty or when the current one leaves
    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= up_data;
        end
    end

endmodule
